// ----- hw/rtl/ipv4_udp_tunnel_rx_check_assert.svh -----
// Assertion macros used by the RTL of the tunnel receive checker.
`ifndef IPV4_UDP_TUNNEL_RX_CHECK_ASSERT_SVH
`define IPV4_UDP_TUNNEL_RX_CHECK_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define IUTRC_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IUTRC_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/iutrc_pkg.sv -----
package iutrc_pkg;

	// Running sum widths: header is at most 30 words, datagram at most 32768 words
	localparam int HSUM_W = 21;
	localparam int DSUM_W = 31;

	localparam int CFG_INDEX_W = 1;

	localparam logic [15:0] TUNNEL_PORT_RESET = 16'd2152;
	localparam logic [7:0]  PROTO_UDP         = 8'd17;
	localparam logic [15:0] FRAG_MASK         = 16'h3fff;
	localparam logic [15:0] SUM_ALL_ONES      = 16'hffff;
	localparam logic [15:0] BYTE_COUNT_MAX    = 16'hffff;

	// Byte offsets of captured IPv4 header fields
	localparam logic [15:0] OFS_VER_IHL  = 16'd0;
	localparam logic [15:0] OFS_TLEN_HI  = 16'd2;
	localparam logic [15:0] OFS_TLEN_LO  = 16'd3;
	localparam logic [15:0] OFS_FRAG_HI  = 16'd6;
	localparam logic [15:0] OFS_FRAG_LO  = 16'd7;
	localparam logic [15:0] OFS_PROTOCOL = 16'd9;
	localparam logic [15:0] OFS_SRC      = 16'd12;
	localparam logic [15:0] OFS_DST      = 16'd16;
	localparam logic [15:0] OFS_HDR_MIN  = 16'd20;

	// UDP header word selects (byte offset within UDP header, bits 2:1)
	localparam logic [1:0] UDP_W_SRC  = 2'd0;
	localparam logic [1:0] UDP_W_DST  = 2'd1;
	localparam logic [1:0] UDP_W_LEN  = 2'd2;
	localparam logic [1:0] UDP_W_CSUM = 2'd3;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_HOST_IP     = 1'b0,
		CFG_TUNNEL_PORT = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		VERDICT_OK        = 4'd0,
		VERDICT_SHORT     = 4'd1,
		VERDICT_VER_IHL   = 4'd2,
		VERDICT_HDR_BUF   = 4'd3,
		VERDICT_TOTAL_LEN = 4'd4,
		VERDICT_HDR_SUM   = 4'd5,
		VERDICT_FRAGMENT  = 4'd6,
		VERDICT_PROTO_DST = 4'd7,
		VERDICT_UDP_LEN   = 4'd8,
		VERDICT_PORT      = 4'd9,
		VERDICT_UDP_SUM   = 4'd10
	} verdict_t;

	// Per-packet capture state
	typedef struct packed {
		logic [15:0]       byte_count;
		logic [7:0]        ver_ihl;
		logic [15:0]       total_length;
		logic [15:0]       frag_field;
		logic [7:0]        protocol;
		logic [HSUM_W-1:0] header_sum;
		logic [DSUM_W-1:0] datagram_sum;
		logic [31:0]       src_addr;
		logic [31:0]       dst_addr;
		logic [15:0]       udp_src;
		logic [15:0]       udp_dst;
		logic [15:0]       udp_len;
		logic [15:0]       udp_csum;
	} pkt_state_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [31:0] source_address;
		logic [15:0] source_port;
		logic [6:0]  payload_offset;
		logic [15:0] payload_length;
	} pkt_result_t;

	// Ones'-complement fold of a 32-bit sum to 16 bits
	function automatic logic [15:0] fold16(input logic [31:0] s);
		logic [16:0] a;
		logic [16:0] b;
		a = {1'b0, s[15:0]} + {1'b0, s[31:16]};
		b = {1'b0, a[15:0]} + {16'd0, a[16]};
		return b[15:0];
	endfunction

endpackage

// ----- hw/rtl/iutrc_judge.sv -----
module iutrc_judge
	import iutrc_pkg::*;
(
	input  pkt_state_t  pkt,
	input  logic [31:0] host_ip,
	input  logic [15:0] tunnel_port,
	output pkt_result_t result
);

	logic [3:0]  ihl;
	logic [5:0]  hlen;
	logic [15:0] hlen16;
	logic [31:0] pseudo_sum;
	logic        bad_short, bad_ver, bad_hdr_buf, bad_tlen, bad_hsum;
	logic        bad_frag, bad_proto_dst, bad_ulen, bad_port, bad_usum;
	verdict_t    verdict;

	assign ihl    = pkt.ver_ihl[3:0];
	assign hlen   = {ihl, 2'b00};
	assign hlen16 = {10'd0, hlen};

	// UDP sum plus pseudo-header
	assign pseudo_sum = {1'b0, pkt.datagram_sum}
		+ {16'd0, pkt.src_addr[31:16]} + {16'd0, pkt.src_addr[15:0]}
		+ {16'd0, pkt.dst_addr[31:16]} + {16'd0, pkt.dst_addr[15:0]}
		+ {24'd0, PROTO_UDP} + {16'd0, pkt.udp_len};

	// Individual checks
	always_comb begin
		bad_short     = pkt.byte_count < OFS_HDR_MIN;
		bad_ver       = (pkt.ver_ihl[7:4] != 4'd4) || (ihl < 4'd5);
		bad_hdr_buf   = hlen16 > pkt.byte_count;
		bad_tlen      = ({1'b0, pkt.total_length} < ({1'b0, hlen16} + 17'd8))
			|| (pkt.total_length > pkt.byte_count);
		bad_hsum      = fold16({{(32-HSUM_W){1'b0}}, pkt.header_sum}) != SUM_ALL_ONES;
		bad_frag      = (pkt.frag_field & FRAG_MASK) != 16'd0;
		bad_proto_dst = (pkt.protocol != PROTO_UDP) || (pkt.dst_addr != host_ip);
		bad_ulen      = (pkt.udp_len < 16'd8) || (pkt.udp_len != (pkt.total_length - hlen16));
		bad_port      = pkt.udp_dst != tunnel_port;
		bad_usum      = (pkt.udp_csum != 16'd0) && (fold16(pseudo_sum) != SUM_ALL_ONES);
	end

	// First failing check wins
	always_comb begin
		if (bad_short)          verdict = VERDICT_SHORT;
		else if (bad_ver)       verdict = VERDICT_VER_IHL;
		else if (bad_hdr_buf)   verdict = VERDICT_HDR_BUF;
		else if (bad_tlen)      verdict = VERDICT_TOTAL_LEN;
		else if (bad_hsum)      verdict = VERDICT_HDR_SUM;
		else if (bad_frag)      verdict = VERDICT_FRAGMENT;
		else if (bad_proto_dst) verdict = VERDICT_PROTO_DST;
		else if (bad_ulen)      verdict = VERDICT_UDP_LEN;
		else if (bad_port)      verdict = VERDICT_PORT;
		else if (bad_usum)      verdict = VERDICT_UDP_SUM;
		else                    verdict = VERDICT_OK;
	end

	always_comb begin
		result.verdict        = verdict;
		result.source_address = pkt.src_addr;
		result.source_port    = pkt.udp_src;
		result.payload_offset = {1'b0, hlen} + 7'd8;
		result.payload_length = (verdict == VERDICT_OK) ? (pkt.udp_len - 16'd8) : 16'd0;
	end

endmodule

// ----- hw/rtl/ipv4_udp_tunnel_rx_check.sv -----
// Channel   Handshake             Payload
// in        in_valid/in_ready     packet_byte, last_byte
// out       out_valid/out_ready   verdict, source_address, source_port,
//                                 payload_offset, payload_length
// cfg       cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One byte per cycle while in_ready is high; the header capture and both running sums update on the byte beat.
// After its last byte, a verdict passes through the snapshot register, then the result register.
// Reset clears capture state, valid flags and config registers (tunnel_port to 2152); no clearing pass.
// in_ready drops only while both the snapshot and result registers hold and out is stalled.
// cfg_ready is always high.
`include "ipv4_udp_tunnel_rx_check_assert.svh"

module ipv4_udp_tunnel_rx_check
	import iutrc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             packet_byte,
	input  logic                   last_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [3:0]             verdict,
	output logic [31:0]            source_address,
	output logic [15:0]            source_port,
	output logic [6:0]             payload_offset,
	output logic [15:0]            payload_length,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]            cfg_data
);

	logic [31:0] host_ip_q;
	logic [15:0] tunnel_port_q;
	pkt_state_t  work_q, work_d;
	pkt_state_t  snap_s1;
	logic        snap_valid_s1;
	pkt_result_t judge_res;
	pkt_result_t res_q;
	logic        res_valid_q;
	logic        in_beat, out_load;
	logic [15:0] pos;
	logic [5:0]  hlen;
	logic [15:0] udp_ofs;
	logic [15:0] word16;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_ip_q     <= '0;
			tunnel_port_q <= TUNNEL_PORT_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HOST_IP:     host_ip_q     <= cfg_data;
				CFG_TUNNEL_PORT: tunnel_port_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Handshake control
	assign out_load = snap_valid_s1 && (!res_valid_q || out_ready);
	assign in_ready = !snap_valid_s1 || out_load;
	assign in_beat  = in_valid && in_ready;

	// Per-byte capture and running sums
	assign pos    = work_q.byte_count;
	assign word16 = pos[0] ? {8'h00, packet_byte} : {packet_byte, 8'h00};

	always_comb begin
		work_d  = work_q;
		hlen    = '0;
		udp_ofs = '0;
		if (pos != BYTE_COUNT_MAX) begin
			work_d.byte_count = pos + 16'd1;
			case (pos)
				OFS_VER_IHL:  work_d.ver_ihl             = packet_byte;
				OFS_TLEN_HI:  work_d.total_length[15:8]  = packet_byte;
				OFS_TLEN_LO:  work_d.total_length[7:0]   = packet_byte;
				OFS_FRAG_HI:  work_d.frag_field[15:8]    = packet_byte;
				OFS_FRAG_LO:  work_d.frag_field[7:0]     = packet_byte;
				OFS_PROTOCOL: work_d.protocol            = packet_byte;
				default: ;
			endcase
			if (pos >= OFS_SRC && pos < OFS_DST)
				work_d.src_addr = {work_q.src_addr[23:0], packet_byte};
			else if (pos >= OFS_DST && pos < OFS_HDR_MIN)
				work_d.dst_addr = {work_q.dst_addr[23:0], packet_byte};

			// header length follows the IHL of this very byte at offset zero
			hlen = {work_d.ver_ihl[3:0], 2'b00};
			if (pos < {10'd0, hlen}) begin
				work_d.header_sum = work_q.header_sum + {{(HSUM_W-16){1'b0}}, word16};
			end else begin
				udp_ofs = pos - {10'd0, hlen};
				if (udp_ofs < 16'd8) begin
					case (udp_ofs[2:1])
						UDP_W_SRC:  work_d.udp_src  = {work_q.udp_src[7:0], packet_byte};
						UDP_W_DST:  work_d.udp_dst  = {work_q.udp_dst[7:0], packet_byte};
						UDP_W_LEN:  work_d.udp_len  = {work_q.udp_len[7:0], packet_byte};
						UDP_W_CSUM: work_d.udp_csum = {work_q.udp_csum[7:0], packet_byte};
						default: ;
					endcase
				end
				if (udp_ofs < 16'd8 || udp_ofs < work_q.udp_len)
					work_d.datagram_sum = work_q.datagram_sum
						+ {{(DSUM_W-16){1'b0}}, word16};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q <= '0;
		end else if (in_beat) begin
			work_q <= last_byte ? '0 : work_d;
		end
	end

	// Snapshot of a finished packet
	always_ff @(posedge clk) begin
		if (in_beat && last_byte) begin
			snap_s1 <= work_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (in_beat && last_byte) begin
			snap_valid_s1 <= 1'b1;
		end else if (out_load) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	iutrc_judge u_judge (
		.pkt         (snap_s1),
		.host_ip     (host_ip_q),
		.tunnel_port (tunnel_port_q),
		.result      (judge_res)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= judge_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_load) begin
			res_valid_q <= 1'b1;
		end else if (out_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	assign out_valid      = res_valid_q;
	assign verdict        = res_q.verdict;
	assign source_address = res_q.source_address;
	assign source_port    = res_q.source_port;
	assign payload_offset = res_q.payload_offset;
	assign payload_length = res_q.payload_length;

	// Checks
	`IUTRC_ASSERT_IMPL(a_len_zero_on_reject, clk, arst_n, res_valid_q && (res_q.verdict != VERDICT_OK), res_q.payload_length == 16'd0, "payload length nonzero on reject")
	`IUTRC_ASSERT_NEXT(a_last_fills_snap, clk, arst_n, in_beat && last_byte, snap_valid_s1, "last byte did not fill snapshot")
	`IUTRC_ASSERT_NEXT(a_last_clears_count, clk, arst_n, in_beat && last_byte, work_q.byte_count == 16'd0, "byte count not cleared after last byte")

endmodule
